### src/peak_autorange_controller_assert.svh
// Assertion macros shared by the checker of the peak autorange controller.
`ifndef PEAK_AUTORANGE_CONTROLLER_ASSERT_SVH
`define PEAK_AUTORANGE_CONTROLLER_ASSERT_SVH

// Property checked on every rising edge of clk while rst is low.
`define PAR_ASSERT_RUN(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Property checked on every rising edge of clk, reset included.
`define PAR_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

### src/par_pkg.sv
`default_nettype none

package par_pkg;

  localparam int SAMPLE_W = 16;
  localparam int PEAK_W   = 16;
  localparam int RANGE_W  = 5;
  localparam int LENGTH_W = 16;
  localparam int THRESH_W = 16;
  localparam int COUNT_W  = 5;

  // Configuration port
  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_BLOCK_LENGTH     = 3'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_MONITOR_ENABLE   = 3'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_AUTORANGE_ENABLE = 3'd2;
  localparam logic [CFG_INDEX_W-1:0] REG_RANGE_COUNT      = 3'd3;
  localparam logic [CFG_INDEX_W-1:0] REG_HIGH_THRESHOLD   = 3'd4;
  localparam logic [CFG_INDEX_W-1:0] REG_LOW_THRESHOLD    = 3'd5;

  localparam logic [LENGTH_W-1:0] BLOCK_LENGTH_RESET = 16'd1024;
  localparam logic [THRESH_W-1:0] HIGH_THRESH_RESET  = 16'd32440;
  localparam logic [THRESH_W-1:0] LOW_THRESH_RESET   = 16'd1638;

  // Queue between the block accumulator and the range stepper
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int QCOUNT_W    = $clog2(QUEUE_DEPTH + 1);

  // Settings seen by the range stepper
  typedef struct packed {
    logic                monitor_enable;
    logic                autorange_enable;
    logic [COUNT_W-1:0]  range_count;
    logic [THRESH_W-1:0] high_threshold;
    logic [THRESH_W-1:0] low_threshold;
  } par_range_cfg_t;

  // Queue status seen by its two neighbours
  typedef struct packed {
    logic full;
    logic not_empty;
  } par_queue_status_t;

endpackage

`default_nettype wire

### src/par_if.sv
`default_nettype none

interface par_sample_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [par_pkg::SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface par_result_if;
  logic                                valid;
  logic                                ready;
  logic        [par_pkg::PEAK_W-1:0]  block_peak;
  logic signed [par_pkg::RANGE_W-1:0] range_index;
  logic                                range_changed;

  modport source (output valid, output block_peak, output range_index,
                  output range_changed, input ready);
  modport sink   (input valid, input block_peak, input range_index,
                  input range_changed, output ready);
endinterface

`default_nettype wire

### src/par_front.sv
`default_nettype none

module par_front (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              valid,
  output logic                                   ready,
  input  wire logic signed [par_pkg::SAMPLE_W-1:0] sample,
  input  wire logic [par_pkg::LENGTH_W-1:0]      block_length,
  input  wire logic                              restart,
  input  wire par_pkg::par_queue_status_t        queue_status,
  output logic                                   push,
  output logic [par_pkg::PEAK_W-1:0]             push_peak
);
  import par_pkg::*;

  logic [LENGTH_W-1:0] sample_counter;
  logic [PEAK_W-1:0]   running_peak;
  logic [PEAK_W-1:0]   magnitude;
  logic [PEAK_W-1:0]   peak_next;
  logic [LENGTH_W:0]   count_inc;
  logic                accept;
  logic                block_end;

  // Two's complement negation keeps the most negative sample as 0x8000.
  assign magnitude = sample[SAMPLE_W-1] ? PEAK_W'(~sample + 1'b1) : PEAK_W'(sample);
  assign peak_next = (magnitude > running_peak) ? magnitude : running_peak;
  assign count_inc = {1'b0, sample_counter} + 1'b1;

  assign ready     = !queue_status.full;
  assign accept    = valid && ready && (block_length != '0);
  assign block_end = count_inc >= {1'b0, block_length};

  assign push      = accept && block_end;
  assign push_peak = peak_next;

  always_ff @(posedge clk) begin
    if (rst || restart) begin
      sample_counter <= '0;
      running_peak   <= '0;
    end else if (accept) begin
      if (block_end) begin
        sample_counter <= '0;
        running_peak   <= '0;
      end else begin
        sample_counter <= count_inc[LENGTH_W-1:0];
        running_peak   <= peak_next;
      end
    end
  end

endmodule

`default_nettype wire

### src/par_queue.sv
`default_nettype none

module par_queue (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           push,
  input  wire logic [par_pkg::PEAK_W-1:0]     push_peak,
  input  wire logic                           pop,
  output logic [par_pkg::PEAK_W-1:0]          head_peak,
  output par_pkg::par_queue_status_t          status
);
  import par_pkg::*;

  logic [PEAK_W-1:0]   entries [QUEUE_DEPTH];
  logic [QPTR_W-1:0]   wr_ptr;
  logic [QPTR_W-1:0]   rd_ptr;
  logic [QCOUNT_W-1:0] fill;
  logic                do_push;
  logic                do_pop;

  assign status.full      = fill == QCOUNT_W'(QUEUE_DEPTH);
  assign status.not_empty = fill != '0;
  assign head_peak        = entries[rd_ptr];

  assign do_push = push && !status.full;
  assign do_pop  = pop && status.not_empty;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_peak;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        fill <= fill + 1'b1;
      end else if (do_pop && !do_push) begin
        fill <= fill - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

### src/par_back.sv
`default_nettype none

module par_back #(
  parameter int MAX_RANGES = 16
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire par_pkg::par_queue_status_t     queue_status,
  input  wire logic [par_pkg::PEAK_W-1:0]     head_peak,
  output logic                                pop,
  input  wire par_pkg::par_range_cfg_t        cfg,
  input  wire logic                           range_clear,
  output logic                                out_valid,
  input  wire logic                           out_ready,
  output logic [par_pkg::PEAK_W-1:0]          out_peak,
  output logic signed [par_pkg::RANGE_W-1:0]  out_range,
  output logic                                out_changed
);
  import par_pkg::*;

  // Signed width that holds -1 up to MAX_RANGES.
  localparam int CR_W = $clog2(MAX_RANGES + 1) + 1;

  logic signed [CR_W-1:0] current_range;
  logic signed [CR_W-1:0] range_next;
  logic signed [CR_W-1:0] count_clamp;
  logic                   holdoff;
  logic                   holdoff_next;
  logic                   step_enable;

  assign pop         = queue_status.not_empty && (!out_valid || out_ready);
  assign step_enable = cfg.monitor_enable && cfg.autorange_enable;
  assign count_clamp = (32'(cfg.range_count) > MAX_RANGES) ? CR_W'(MAX_RANGES)
                                                           : CR_W'(cfg.range_count);

  always_comb begin
    range_next   = current_range;
    holdoff_next = holdoff;
    if (step_enable) begin
      if (holdoff) begin
        holdoff_next = 1'b0;
      end else if (count_clamp != '0) begin
        // The down step goes first; the up step sees its result.
        if ((head_peak >= cfg.high_threshold) && (range_next > 0)) begin
          range_next   = range_next - 1'b1;
          holdoff_next = 1'b1;
        end
        if ((head_peak <= cfg.low_threshold) && (range_next < count_clamp - CR_W'(1))) begin
          range_next   = range_next + 1'b1;
          holdoff_next = 1'b1;
        end
        if (range_next == -1) begin
          range_next = '0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      current_range <= '1;
      holdoff       <= 1'b1;
    end else if (range_clear) begin
      current_range <= '1;
    end else if (pop) begin
      current_range <= range_next;
      holdoff       <= holdoff_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (pop) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      out_peak    <= head_peak;
      out_range   <= RANGE_W'(range_next);
      out_changed <= range_next != current_range;
    end
  end

endmodule

`default_nettype wire

### src/peak_autorange_controller.sv
`default_nettype none

// Peak autorange controller. Signed Q1.15 samples arrive as beats on the
// samples channel; over each block of block_length samples the largest
// magnitude is tracked, and at the end of the block one beat leaves on the
// results channel with that peak, the range index after the block and a flag
// telling whether the block moved the range. While both enables are set, a
// range step runs at each block end once a one-block hold-off has expired: a
// peak at or above high_threshold lowers the index, a peak at or below
// low_threshold raises it up to the last range, and an unset index (-1)
// becomes 0. The block takes one sample every clock cycle while its internal
// queue has room; a block's peak passes through the queue into the output
// register. The samples channel only drops ready when the two-entry queue
// between the block accumulator and the range stepper is full, which happens
// only while the results channel is stalled. Writing block_length restarts
// the current block, and writing range_count clears the range to unset; the
// user writes registers only while the block is idle; the block does not enforce it.
module peak_autorange_controller #(
  parameter int MAX_RANGES = 16
) (
  input  wire logic                               clk,
  input  wire logic                               rst,
  par_sample_if.sink                              samples,
  par_result_if.source                            results,
  input  wire logic                               cfg_write_enable,
  input  wire logic [par_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  wire logic [par_pkg::CFG_DATA_W-1:0]     cfg_data
);
  import par_pkg::*;

  // Configuration registers.
  logic [LENGTH_W-1:0] block_length;
  par_range_cfg_t      range_cfg;
  logic                restart;
  logic                range_clear;

  // Handshake between the accumulator, the queue and the stepper.
  par_queue_status_t   queue_status;
  logic                push;
  logic [PEAK_W-1:0]   push_peak;
  logic                pop;
  logic [PEAK_W-1:0]   head_peak;

  assign restart     = cfg_write_enable && (cfg_index == REG_BLOCK_LENGTH);
  assign range_clear = cfg_write_enable && (cfg_index == REG_RANGE_COUNT);

  always_ff @(posedge clk) begin
    if (rst) begin
      block_length               <= BLOCK_LENGTH_RESET;
      range_cfg.monitor_enable   <= 1'b1;
      range_cfg.autorange_enable <= 1'b0;
      range_cfg.range_count      <= '0;
      range_cfg.high_threshold   <= HIGH_THRESH_RESET;
      range_cfg.low_threshold    <= LOW_THRESH_RESET;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_BLOCK_LENGTH:     block_length               <= cfg_data[LENGTH_W-1:0];
        REG_MONITOR_ENABLE:   range_cfg.monitor_enable   <= cfg_data[0];
        REG_AUTORANGE_ENABLE: range_cfg.autorange_enable <= cfg_data[0];
        REG_RANGE_COUNT:      range_cfg.range_count      <= cfg_data[COUNT_W-1:0];
        REG_HIGH_THRESHOLD:   range_cfg.high_threshold   <= cfg_data[THRESH_W-1:0];
        REG_LOW_THRESHOLD:    range_cfg.low_threshold    <= cfg_data[THRESH_W-1:0];
        default: begin
          // Writes to unused indexes are dropped.
        end
      endcase
    end
  end

  // Front end: magnitude, running peak and block counting.
  par_front u_front (
    .clk          (clk),
    .rst          (rst),
    .valid        (samples.valid),
    .ready        (samples.ready),
    .sample       (samples.sample),
    .block_length (block_length),
    .restart      (restart),
    .queue_status (queue_status),
    .push         (push),
    .push_peak    (push_peak)
  );

  // Finished block peaks wait here so that each side can stall on its own.
  par_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_peak (push_peak),
    .pop       (pop),
    .head_peak (head_peak),
    .status    (queue_status)
  );

  // Back end: hold-off, range step and the output register.
  par_back #(
    .MAX_RANGES (MAX_RANGES)
  ) u_back (
    .clk          (clk),
    .rst          (rst),
    .queue_status (queue_status),
    .head_peak    (head_peak),
    .pop          (pop),
    .cfg          (range_cfg),
    .range_clear  (range_clear),
    .out_valid    (results.valid),
    .out_ready    (results.ready),
    .out_peak     (results.block_peak),
    .out_range    (results.range_index),
    .out_changed  (results.range_changed)
  );

endmodule

`default_nettype wire

### src/par_checker.sv
`default_nettype none

`include "peak_autorange_controller_assert.svh"

module par_checker (
  input wire logic                              clk,
  input wire logic                              rst,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [par_pkg::PEAK_W-1:0]        out_peak
);
  import par_pkg::*;

  // A stalled result beat stays offered.
  `PAR_ASSERT_RUN(a_out_hold, out_valid && !out_ready |=> out_valid, "result beat dropped while stalled")

  // A block peak is a magnitude of a Q1.15 sample and cannot pass full scale.
  `PAR_ASSERT_RUN(a_peak_bound, out_valid |-> out_peak <= PEAK_W'(17'h08000), "block peak above full scale")

  // Reset empties the output register.
  `PAR_ASSERT_ALWAYS(a_reset_empty, rst |=> !out_valid, "result offered right after reset")

  // A fresh result follows the sample that closed its block, through the queue and the output register.
  `PAR_ASSERT_RUN(a_latency, $rose(out_valid) |-> $past(in_valid && in_ready, 2), "result without a closing sample")

endmodule

bind peak_autorange_controller par_checker u_par_checker (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (samples.valid),
  .in_ready  (samples.ready),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_peak  (results.block_peak)
);

`default_nettype wire

### verif/par_peak_checker.sv
`default_nettype none

// Watches both channels and the register port of the peak autorange
// controller, keeps its own copy of the block state, and compares every
// result beat with the oldest outstanding prediction.
module par_peak_checker #(
  parameter int MAX_RANGES = 16
) (
  input  wire logic                            clk,
  input  wire logic                            rst,
  par_sample_if                                samples,
  par_result_if                                results,
  input  wire logic                            cfg_write_enable,
  input  wire logic [par_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [par_pkg::CFG_DATA_W-1:0]  cfg_data,
  output int                                   error_count,
  output int                                   results_owed
);
  timeunit 1ns;
  timeprecision 1ps;
  import par_pkg::*;

  typedef struct packed {
    logic [PEAK_W-1:0]         block_peak;
    logic signed [RANGE_W-1:0] range_index;
    logic                      range_changed;
  } peak_result_t;

  // Register copies.
  logic [LENGTH_W-1:0] blk_len;
  logic                mon_en;
  logic                auto_en;
  logic [COUNT_W-1:0]  n_ranges;
  logic [THRESH_W-1:0] hi_th;
  logic [THRESH_W-1:0] lo_th;

  // Block state.
  logic [LENGTH_W-1:0] taken;
  logic [PEAK_W-1:0]   peak_so_far;
  logic                holdoff;
  int                  cur_range;

  peak_result_t owed_q[$];

  initial begin
    error_count  = 0;
    results_owed = 0;
  end

  always @(posedge clk) begin : track
    peak_result_t      want;
    logic [PEAK_W-1:0] mag;
    logic [PEAK_W-1:0] peak;
    int                usable;
    int                prev_range;

    if (rst) begin
      blk_len     = BLOCK_LENGTH_RESET;
      mon_en      = 1'b1;
      auto_en     = 1'b0;
      n_ranges    = '0;
      hi_th       = HIGH_THRESH_RESET;
      lo_th       = LOW_THRESH_RESET;
      taken       = '0;
      peak_so_far = '0;
      holdoff     = 1'b1;
      cur_range   = -1;
      owed_q.delete();
    end else begin
      // Results first, so that a beat with nothing owed is caught even when
      // a new prediction is made on the same edge.
      if (results.valid && results.ready) begin
        if (owed_q.size() == 0) begin
          error_count++;
          $display("%0t: result beat with none expected: peak %0d range %0d changed %0b",
                   $time, results.block_peak, results.range_index, results.range_changed);
        end else begin
          want = owed_q.pop_front();
          if (results.block_peak !== want.block_peak) begin
            error_count++;
            $display("%0t: block_peak expected %0d actual %0d",
                     $time, want.block_peak, results.block_peak);
          end
          if (results.range_index !== want.range_index) begin
            error_count++;
            $display("%0t: range_index expected %0d actual %0d",
                     $time, want.range_index, results.range_index);
          end
          if (results.range_changed !== want.range_changed) begin
            error_count++;
            $display("%0t: range_changed expected %0b actual %0b",
                     $time, want.range_changed, results.range_changed);
          end
        end
      end

      if (cfg_write_enable) begin
        case (cfg_index)
          REG_BLOCK_LENGTH: begin
            blk_len     = cfg_data[LENGTH_W-1:0];
            taken       = '0;
            peak_so_far = '0;
          end
          REG_MONITOR_ENABLE:   mon_en  = cfg_data[0];
          REG_AUTORANGE_ENABLE: auto_en = cfg_data[0];
          REG_RANGE_COUNT: begin
            n_ranges  = cfg_data[COUNT_W-1:0];
            cur_range = -1;
          end
          REG_HIGH_THRESHOLD: hi_th = cfg_data[THRESH_W-1:0];
          REG_LOW_THRESHOLD:  lo_th = cfg_data[THRESH_W-1:0];
          default: ;
        endcase
      end

      // A zero block length makes the block ignore its samples altogether.
      if (samples.valid && samples.ready && blk_len != '0) begin
        mag = samples.sample[SAMPLE_W-1] ? PEAK_W'(-samples.sample) : PEAK_W'(samples.sample);
        if (mag > peak_so_far)
          peak_so_far = mag;
        taken = taken + 1'b1;
        if (taken >= blk_len) begin
          peak        = peak_so_far;
          taken       = '0;
          peak_so_far = '0;
          prev_range  = cur_range;
          if (mon_en && auto_en) begin
            usable = (n_ranges > MAX_RANGES) ? MAX_RANGES : int'(n_ranges);
            if (holdoff) begin
              holdoff = 1'b0;
            end else if (usable != 0) begin
              // The down step goes first; the up step sees the new index.
              if (peak >= hi_th && cur_range > 0) begin
                cur_range--;
                holdoff = 1'b1;
              end
              if (peak <= lo_th && cur_range < usable - 1) begin
                cur_range++;
                holdoff = 1'b1;
              end
              if (cur_range == -1)
                cur_range = 0;
            end
          end
          want.block_peak    = peak;
          want.range_index   = RANGE_W'(cur_range);
          want.range_changed = (cur_range != prev_range);
          owed_q.push_back(want);
        end
      end
    end
    results_owed = owed_q.size();
  end

endmodule

`default_nettype wire

### verif/tb_peak_autorange_controller.sv
`default_nettype none

// Stimulus and verdict for the peak autorange controller. The checker beside
// the block does all prediction and comparison; this module only drives the
// sample beats, the result ready, and the register port, then reads the
// failure count back at the end.
module tb_peak_autorange_controller;
  timeunit 1ns;
  timeprecision 1ps;
  import par_pkg::*;

  localparam int MAX_RANGES     = 16;
  localparam int RANDOM_ITEMS   = 1450;
  // Cycles with no beat on either channel before the run is declared hung.
  // The longest legitimate quiet stretch is the receiver hold-off below.
  localparam int STALL_LIMIT    = 2000;
  localparam int RX_HOLD_CYCLES = 200;
  // Results pass through the queue and the output register after the last sample
  // of a block; wait a good margin beyond that before touching the registers.
  localparam int QUIET_CYCLES   = 8;

  // Register indexes that map to nothing; writes there must be ignored.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_HI = 3'd7;

  logic                   clk;
  logic                   rst;
  logic                   cfg_write_enable;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  par_sample_if samples ();
  par_result_if results ();

  int error_count;
  int results_owed;

  // Idle percentages for each side, and a request count that the receiver
  // turns into a long hold-off of its own.
  int tx_idle_pct   = 30;
  int rx_idle_pct   = 30;
  int hold_requests = 0;
  int stall_cycles  = 0;
  int random_items  = 0;

  // Last values written, so that random samples can be aimed at the
  // thresholds and at the current block length.
  int bl_set  = BLOCK_LENGTH_RESET;
  int th_high = HIGH_THRESH_RESET;
  int th_low  = LOW_THRESH_RESET;

  logic signed [SAMPLE_W-1:0] directed_q[$];

  peak_autorange_controller #(
    .MAX_RANGES(MAX_RANGES)
  ) dut (
    .clk             (clk),
    .rst             (rst),
    .samples         (samples),
    .results         (results),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  par_peak_checker #(
    .MAX_RANGES(MAX_RANGES)
  ) peak_check (
    .clk             (clk),
    .rst             (rst),
    .samples         (samples),
    .results         (results),
    .cfg_write_enable(cfg_write_enable),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .error_count     (error_count),
    .results_owed    (results_owed)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // One register write per cycle. The enable is left high so that writes in
  // a row follow each other without a gap; the caller lowers it afterwards.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] value);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= value;
    case (idx)
      REG_BLOCK_LENGTH:   bl_set  = value;
      REG_HIGH_THRESHOLD: th_high = value;
      REG_LOW_THRESHOLD:  th_low  = value;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Offers one sample beat after a random number of idle cycles and returns
  // once it has been taken. Valid stays high on return, so back-to-back
  // beats never drop it within a time step.
  task automatic send_sample(input logic signed [SAMPLE_W-1:0] value);
    while ($urandom_range(99) < tx_idle_pct) begin
      samples.valid <= 1'b0;
      @(posedge clk);
    end
    samples.valid  <= 1'b1;
    samples.sample <= value;
    do @(posedge clk); while (!samples.ready);
  endtask

  // Stops offering samples and waits until every predicted result has been
  // taken and the block has had time to settle. This is also the point at
  // which the sender pauses for the results to catch up.
  task automatic drain();
    int quiet;
    cfg_write_enable <= 1'b0;
    samples.valid    <= 1'b0;
    quiet = 0;
    while (quiet < QUIET_CYCLES) begin
      @(posedge clk);
      quiet = (results_owed == 0) ? quiet + 1 : 0;
    end
  endtask

  task automatic send_directed();
    cfg_write_enable <= 1'b0;
    foreach (directed_q[i])
      send_sample(directed_q[i]);
    drain();
  endtask

  // Random samples: the extremes of the field, fully random words, small
  // magnitudes around the low threshold and large ones around the high one.
  task automatic send_random(input int count);
    int r;
    int m;
    int centre;
    logic signed [SAMPLE_W-1:0] value;
    cfg_write_enable <= 1'b0;
    repeat (count) begin
      r = $urandom_range(9);
      m = 0;
      if (r == 0) begin
        value = 16'sh8000;
      end else if (r == 1) begin
        value = 16'sh7FFF;
      end else if (r <= 4) begin
        value = SAMPLE_W'($urandom);
      end else begin
        if (r <= 6)
          m = $urandom_range(0, (th_low + 2 > 32768) ? 32768 : th_low + 2);
        else begin
          centre = (th_high > 32768) ? 32768 : th_high;
          m = centre + int'($urandom_range(4)) - 2;
          if (m < 0) m = 0;
          if (m > 32768) m = 32768;
        end
        value = $urandom_range(1) ? SAMPLE_W'(-m) : SAMPLE_W'(m);
      end
      send_sample(value);
      if (bl_set != 0)
        random_items++;
    end
  endtask

  // Receiver: random ready, except during a requested hold-off, which it
  // counts out itself while the sender keeps offering beats.
  initial begin : receiver
    int hold_left;
    int hold_seen;
    hold_left = 0;
    hold_seen = 0;
    results.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_requests != hold_seen) begin
        hold_seen = hold_requests;
        hold_left = RX_HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        results.ready <= 1'b0;
        hold_left--;
      end else begin
        results.ready <= ($urandom_range(99) >= rx_idle_pct);
      end
    end
  end

  // Watchdog: the run is hung if no beat moves on either channel for too long.
  always @(posedge clk) begin
    if (rst || (samples.valid && samples.ready) || (results.valid && results.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("tb_peak_autorange_controller: done, errors");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int phase;
    int count;
    int r;

    rst              <= 1'b1;
    samples.valid    <= 1'b0;
    samples.sample   <= '0;
    cfg_write_enable <= 1'b0;
    cfg_index        <= '0;
    cfg_data         <= '0;

    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed part. Block length one makes every sample a result, so the
    // hold-off and each range step can be walked through beat by beat. The
    // first block after reset is only the hold-off; the unset range then
    // steps up to zero and on upwards; of the full-scale peaks of both signs, the
    // negative one steps it back down, while the positive ones fall in a hold-off.
    write_reg(REG_BLOCK_LENGTH, 16'd1);
    write_reg(REG_AUTORANGE_ENABLE, 16'd1);
    write_reg(REG_RANGE_COUNT, 16'd4);
    directed_q = '{0, 0, 0, 0, 32767, -32768, 32767, -1, 1};
    send_directed();

    // Both thresholds met by the same peak: down first, then up again.
    write_reg(REG_HIGH_THRESHOLD, 16'd100);
    write_reg(REG_LOW_THRESHOLD, 16'd200);
    directed_q = '{150, 150, 150};
    send_directed();

    // Range count beyond the number of ranges, and the threshold extremes:
    // only the most negative sample reaches a high threshold of full scale.
    write_reg(REG_RANGE_COUNT, 16'd20);
    write_reg(REG_HIGH_THRESHOLD, 16'd32768);
    write_reg(REG_LOW_THRESHOLD, 16'd0);
    directed_q = '{0, 0, -32768, 0};
    send_directed();

    // No ranges: the hold-off still counts down but nothing steps.
    write_reg(REG_RANGE_COUNT, 16'd0);
    directed_q = '{0, 0};
    send_directed();

    // Each enable cleared in turn: the range and the hold-off stay put.
    write_reg(REG_MONITOR_ENABLE, 16'd0);
    directed_q = '{0};
    send_directed();
    write_reg(REG_MONITOR_ENABLE, 16'd1);
    write_reg(REG_AUTORANGE_ENABLE, 16'd0);
    directed_q = '{0};
    send_directed();

    // Zero block length swallows samples; writes to the spare indexes do
    // nothing.
    write_reg(REG_BLOCK_LENGTH, 16'd0);
    write_reg(REG_SPARE_LO, 16'hFFFF);
    write_reg(REG_SPARE_HI, 16'hFFFF);
    directed_q = '{5, -5};
    send_directed();

    // A block left half full is thrown away by a block length write.
    write_reg(REG_BLOCK_LENGTH, 16'd3);
    write_reg(REG_AUTORANGE_ENABLE, 16'd1);
    directed_q = '{7, -9};
    send_directed();
    write_reg(REG_BLOCK_LENGTH, 16'd2);
    directed_q = '{3, 4};
    send_directed();

    // Random part: each phase waits for the block to go idle, rewrites a
    // random selection of registers, then sends a burst of samples. Short
    // blocks keep results frequent so that the range logic is exercised
    // many times over.
    phase = 0;
    while (random_items < RANDOM_ITEMS) begin
      drain();

      r = $urandom_range(99);
      if (r < 10)
        write_reg(REG_BLOCK_LENGTH, 16'd0);
      else if (r < 75)
        write_reg(REG_BLOCK_LENGTH, CFG_DATA_W'($urandom_range(1, 4)));
      else
        write_reg(REG_BLOCK_LENGTH, CFG_DATA_W'($urandom_range(5, 16)));

      // Upper data bits are random; only bit zero matters for the enables.
      if ($urandom_range(3) == 0)
        write_reg(REG_MONITOR_ENABLE, {15'($urandom), 1'($urandom_range(9) != 0)});
      if ($urandom_range(2) == 0)
        write_reg(REG_AUTORANGE_ENABLE, {15'($urandom), 1'($urandom_range(4) != 0)});
      if ($urandom_range(2) == 0) begin
        if ($urandom_range(99) < 70)
          write_reg(REG_RANGE_COUNT, CFG_DATA_W'($urandom_range(1, 16)));
        else
          write_reg(REG_RANGE_COUNT, CFG_DATA_W'($urandom));
      end
      if ($urandom_range(1) == 0) begin
        r = $urandom_range(4);
        if (r == 0)
          write_reg(REG_HIGH_THRESHOLD, CFG_DATA_W'($urandom));
        else if (r == 1)
          write_reg(REG_HIGH_THRESHOLD, 16'd32768);
        else
          write_reg(REG_HIGH_THRESHOLD, CFG_DATA_W'($urandom_range(16000, 32767)));
      end
      if ($urandom_range(1) == 0) begin
        r = $urandom_range(4);
        if (r == 0)
          write_reg(REG_LOW_THRESHOLD, CFG_DATA_W'($urandom));
        else if (r == 1)
          write_reg(REG_LOW_THRESHOLD, 16'd0);
        else
          write_reg(REG_LOW_THRESHOLD, CFG_DATA_W'($urandom_range(0, 12000)));
      end
      if ($urandom_range(9) == 0)
        write_reg($urandom_range(1) ? REG_SPARE_LO : REG_SPARE_HI, CFG_DATA_W'($urandom));

      if (phase == 2) begin
        // A long stretch with neither side idling, with results flowing.
        write_reg(REG_BLOCK_LENGTH, 16'd2);
        tx_idle_pct = 0;
        rx_idle_pct <= 0;
        count = 300;
      end else if (phase == 5) begin
        // Back pressure: one result per sample while the receiver holds off,
        // so the internal queue fills and the sample channel stalls.
        write_reg(REG_BLOCK_LENGTH, 16'd1);
        tx_idle_pct = 0;
        rx_idle_pct <= 30;
        hold_requests <= hold_requests + 1;
        count = 60;
      end else begin
        tx_idle_pct = 30;
        rx_idle_pct <= 30;
        count = (bl_set == 0) ? 5 : $urandom_range(20, 80);
      end
      send_random(count);
      phase++;
    end

    drain();
    if (error_count == 0 && results_owed == 0)
      $display("tb_peak_autorange_controller: done, clean");
    else
      $display("tb_peak_autorange_controller: done, errors");
    $finish;
  end

endmodule

`default_nettype wire

### filelist.f
+incdir+src
src/par_pkg.sv
src/par_if.sv
src/par_front.sv
src/par_queue.sv
src/par_back.sv
src/peak_autorange_controller.sv
src/par_checker.sv
verif/par_peak_checker.sv
verif/tb_peak_autorange_controller.sv
